/* hdl/sira_pkg.sv */
// ----------------------------------------------------------------------------
// sira_pkg
// Shared types, constants, reciprocal table and microcode for the signed
// integer to radix ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sira_pkg;

   localparam int WORD_BITS  = 32;
   localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
   localparam int IDX_BITS   = $clog2(WORD_BITS);
   localparam int RADIX_BITS = 6;
   localparam int DIGIT_BITS = 6;
   localparam int CHAR_BITS  = 7;
   localparam int STEP_BITS  = 3;
   localparam int OP_BITS    = 3;
   localparam int COND_BITS  = 2;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [DIGIT_BITS-1:0] DEC_DIGITS  = 6'd10;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 7'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 7'h5A;

   // floor(2^WORD_BITS / radix); quotient estimate is exact or one low
   localparam logic [WORD_BITS:0] RECIP_NUM = {1'b1, {WORD_BITS{1'b0}}};

   localparam logic [WORD_BITS-1:0] RECIP_TABLE [0:36] = '{
      WORD_BITS'(RECIP_NUM / 2),  WORD_BITS'(RECIP_NUM / 2),  WORD_BITS'(RECIP_NUM / 2),
      WORD_BITS'(RECIP_NUM / 3),  WORD_BITS'(RECIP_NUM / 4),  WORD_BITS'(RECIP_NUM / 5),
      WORD_BITS'(RECIP_NUM / 6),  WORD_BITS'(RECIP_NUM / 7),  WORD_BITS'(RECIP_NUM / 8),
      WORD_BITS'(RECIP_NUM / 9),  WORD_BITS'(RECIP_NUM / 10), WORD_BITS'(RECIP_NUM / 11),
      WORD_BITS'(RECIP_NUM / 12), WORD_BITS'(RECIP_NUM / 13), WORD_BITS'(RECIP_NUM / 14),
      WORD_BITS'(RECIP_NUM / 15), WORD_BITS'(RECIP_NUM / 16), WORD_BITS'(RECIP_NUM / 17),
      WORD_BITS'(RECIP_NUM / 18), WORD_BITS'(RECIP_NUM / 19), WORD_BITS'(RECIP_NUM / 20),
      WORD_BITS'(RECIP_NUM / 21), WORD_BITS'(RECIP_NUM / 22), WORD_BITS'(RECIP_NUM / 23),
      WORD_BITS'(RECIP_NUM / 24), WORD_BITS'(RECIP_NUM / 25), WORD_BITS'(RECIP_NUM / 26),
      WORD_BITS'(RECIP_NUM / 27), WORD_BITS'(RECIP_NUM / 28), WORD_BITS'(RECIP_NUM / 29),
      WORD_BITS'(RECIP_NUM / 30), WORD_BITS'(RECIP_NUM / 31), WORD_BITS'(RECIP_NUM / 32),
      WORD_BITS'(RECIP_NUM / 33), WORD_BITS'(RECIP_NUM / 34), WORD_BITS'(RECIP_NUM / 35),
      WORD_BITS'(RECIP_NUM / 36)
   };

   // microcode operations
   localparam logic [OP_BITS-1:0] OP_LOAD  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_MUL   = 3'd1;
   localparam logic [OP_BITS-1:0] OP_DIV   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_SIGN  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_PRIME = 3'd4;
   localparam logic [OP_BITS-1:0] OP_EMIT  = 3'd5;
   localparam logic [OP_BITS-1:0] OP_NOP   = 3'd6;

   // branch conditions
   localparam logic [COND_BITS-1:0] COND_NEXT   = 2'd0;
   localparam logic [COND_BITS-1:0] COND_ALWAYS = 2'd1;
   localparam logic [COND_BITS-1:0] COND_TEST   = 2'd2;

   // program addresses
   localparam logic [STEP_BITS-1:0] STEP_LOAD = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_MUL  = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_EMIT = 3'd5;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [COND_BITS-1:0] cond;
      logic [STEP_BITS-1:0] target;
   } sira_uword_type;

   localparam sira_uword_type UCODE [0:7] = '{
      '{op: OP_LOAD,  cond: COND_NEXT,   target: STEP_LOAD},
      '{op: OP_MUL,   cond: COND_NEXT,   target: STEP_LOAD},
      '{op: OP_DIV,   cond: COND_TEST,   target: STEP_MUL},
      '{op: OP_SIGN,  cond: COND_NEXT,   target: STEP_LOAD},
      '{op: OP_PRIME, cond: COND_NEXT,   target: STEP_LOAD},
      '{op: OP_EMIT,  cond: COND_TEST,   target: STEP_EMIT},
      '{op: OP_NOP,   cond: COND_ALWAYS, target: STEP_LOAD},
      '{op: OP_NOP,   cond: COND_ALWAYS, target: STEP_LOAD}
   };

   function automatic logic [RADIX_BITS-1:0] sat_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d < DEC_DIGITS) begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         c = CHAR_UPPER_A + CHAR_BITS'(d - DEC_DIGITS);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* hdl/sira_req_if.sv */
// ----------------------------------------------------------------------------
// sira_req_if
// Request channel: one signed integer word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sira_req_if import sira_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

/* hdl/sira_rsp_if.sv */
// ----------------------------------------------------------------------------
// sira_rsp_if
// Response channel: one ASCII character word per handshake, last on the end.
// ----------------------------------------------------------------------------
`default_nettype none

interface sira_rsp_if import sira_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] ascii_char;
   logic                 last;

   modport source (output valid, output ascii_char, output last, input ready);
   modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

`default_nettype wire

/* hdl/sira_div.sv */
// ----------------------------------------------------------------------------
// sira_div
// Divide by the radix: registered reciprocal product, then
// quotient estimate with a single correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module sira_div import sira_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  mul_en,
   input  wire logic [WORD_BITS-1:0]  mag,
   input  wire logic [WORD_BITS-1:0]  recip,
   input  wire logic [RADIX_BITS-1:0] radix,
   output logic      [WORD_BITS-1:0]  quot,
   output logic      [DIGIT_BITS-1:0] rem
);

   logic [2*WORD_BITS-1:0]          prod_ff;
   logic [2*WORD_BITS-1:0]          prod_in;
   logic [WORD_BITS-1:0]            q_est;
   logic [WORD_BITS+RADIX_BITS-1:0] q_times_r;
   logic [WORD_BITS-1:0]            r_est;
   logic                            fix;

   assign prod_in = mag * recip;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      q_est     = prod_ff[2*WORD_BITS-1:WORD_BITS];
      q_times_r = q_est * radix;
      // estimate is at most one low, so the raw remainder is below 2*radix
      r_est     = mag - q_times_r[WORD_BITS-1:0];
      fix       = (r_est >= WORD_BITS'(radix));
      quot      = fix ? (q_est + WORD_BITS'(1)) : q_est;
      rem       = fix ? DIGIT_BITS'(r_est - WORD_BITS'(radix)) : DIGIT_BITS'(r_est);
   end

endmodule

`default_nettype wire

/* hdl/signed_integer_to_radix_ascii_top.sv */
// ----------------------------------------------------------------------------
// signed_integer_to_radix_ascii_top
// Converts a signed integer word to ASCII text in a programmable radix,
// driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------
//  req_bus | in  | valid / ready      | value [31:0] signed
//  rsp_bus | out | valid / ready      | ascii_char [6:0], last
//  csr     | in  | csr_we (no ready)  | csr_wdata [5:0] = radix
//
//  An item of n digits (1..32 digits) passes through two steps per digit
//  in the reciprocal divide unit, one emit step per digit out of the
//  digit store, plus load, sign, prime and return steps.
//  Reset is synchronous and active high; radix resets to 10.
//  A stalled output holds the sequencer in its sign or emit step; the next
//  word is taken as soon as the program is back at its load step.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_ascii_top import sira_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [RADIX_BITS-1:0] csr_wdata,
   sira_req_if.sink                   req_bus,
   sira_rsp_if.source                 rsp_bus
);

   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [WORD_BITS-1:0]  recip_ff;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [WORD_BITS-1:0]  mag_ff, mag_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [DIGIT_BITS-1:0] rd_ff;

   logic [DIGIT_BITS-1:0] digit_mem [0:WORD_BITS-1];

   sira_uword_type        uw;
   logic                  adv, cond_true, jump;
   logic                  mul_en, wr_en, rd_en, out_load, out_free;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [CNT_BITS-1:0]   cnt_p1, cnt_m1, cnt_m2;
   logic [WORD_BITS-1:0]  raw;
   logic [WORD_BITS-1:0]  quot;
   logic [DIGIT_BITS-1:0] rem;

   sira_div u_div (
      .clock  (clock),
      .mul_en (mul_en),
      .mag    (mag_ff),
      .recip  (recip_ff),
      .radix  (radix_ff),
      .quot   (quot),
      .rem    (rem)
   );

   assign radix_in      = sat_radix(csr_wdata);
   assign req_bus.ready = (step_ff == STEP_LOAD);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign raw           = req_bus.value;
   assign cnt_p1        = cnt_ff + CNT_BITS'(1);
   assign cnt_m1        = cnt_ff - CNT_BITS'(1);
   assign cnt_m2        = cnt_ff - CNT_BITS'(2);

   always_comb begin
      uw           = UCODE[step_ff];
      adv          = 1'b0;
      cond_true    = 1'b0;
      mul_en       = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      out_load     = 1'b0;
      rd_addr      = cnt_m1[IDX_BITS-1:0];
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (uw.op)
         OP_LOAD: begin
            adv = req_bus.valid;
            if (req_bus.valid) begin
               neg_in = raw[WORD_BITS-1];
               mag_in = raw[WORD_BITS-1] ? (~raw + WORD_BITS'(1)) : raw;
               cnt_in = '0;
            end
         end
         OP_MUL: begin
            adv    = 1'b1;
            mul_en = 1'b1;
         end
         OP_DIV: begin
            // runs at least once, so zero yields the single digit 0
            adv       = 1'b1;
            wr_en     = 1'b1;
            mag_in    = quot;
            cnt_in    = cnt_p1;
            cond_true = (quot != '0) && (cnt_p1 < CNT_BITS'(WORD_BITS));
         end
         OP_SIGN: begin
            adv = !neg_ff || out_free;
            if (neg_ff && out_free) begin
               out_load    = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
            end
         end
         OP_PRIME: begin
            adv   = 1'b1;
            rd_en = 1'b1;
         end
         OP_EMIT: begin
            adv       = out_free;
            cond_true = (cnt_ff != CNT_BITS'(1));
            rd_addr   = cnt_m2[IDX_BITS-1:0];
            if (out_free) begin
               out_load    = 1'b1;
               rd_en       = 1'b1;
               rsp_char_in = digit_to_ascii(rd_ff);
               rsp_last_in = (cnt_ff == CNT_BITS'(1));
               cnt_in      = cnt_m1;
            end
         end
         OP_NOP: begin
            adv = 1'b1;
         end
         default: begin
            adv = 1'b1;
         end
      endcase

      unique case (uw.cond)
         COND_NEXT:   jump = 1'b0;
         COND_ALWAYS: jump = 1'b1;
         COND_TEST:   jump = cond_true;
         default:     jump = 1'b0;
      endcase

      if (!adv) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = uw.target;
      end else begin
         step_in = step_ff + STEP_BITS'(1);
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         recip_ff     <= RECIP_TABLE[RADIX_RESET];
         step_ff      <= STEP_LOAD;
         mag_ff       <= '0;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            radix_ff <= radix_in;
            recip_ff <= RECIP_TABLE[radix_in];
         end
         step_ff      <= step_in;
         mag_ff       <= mag_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // digit store, least significant digit at entry 0
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[cnt_ff[IDX_BITS-1:0]] <= rem;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= digit_mem[rd_addr];
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.ascii_char = rsp_char_ff;
   assign rsp_bus.last       = rsp_last_ff;

endmodule

`default_nettype wire

/* hdl/sira_checker.sv */
// ----------------------------------------------------------------------------
// sira_checker
// Port-level assertions for the radix ASCII converter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sira_checker import sira_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [CHAR_BITS-1:0] rsp_char,
   input wire logic                 rsp_last
);

   // stalled word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // an accepted word starts a conversion, so input closes next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken twice in a row");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char == CHAR_MINUS)
                 || (rsp_char >= CHAR_ZERO && rsp_char <= CHAR_NINE)
                 || (rsp_char >= CHAR_UPPER_A && rsp_char <= CHAR_UPPER_Z))
      else $error("illegal character on rsp");

   // a sign is always followed by at least one digit
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_char == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign marked last");

endmodule

bind signed_integer_to_radix_ascii_top sira_checker u_sira_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_char  (rsp_bus.ascii_char),
   .rsp_last  (rsp_bus.last)
);

`default_nettype wire

/* bench/signed_integer_to_radix_ascii_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_ascii_top_tb
// Feeds signed integer words to the converter across a range of radix
// settings, including the saturated ones below 2 and above 36. Each accepted
// word is turned into its expected character string, and every character
// that comes out is checked in order against it. Both channels idle and
// stall at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------

module signed_integer_to_radix_ascii_top_tb;
   import sira_pkg::*;

   typedef struct packed {
      logic [CHAR_BITS-1:0] ascii_char;
      logic                 last;
   } text_char_type;

   class radix_text_scoreboard;
      text_char_type         expected_text[$];
      logic [RADIX_BITS-1:0] radix_reg;
      int                    faults;

      function new();
         radix_reg = RADIX_RESET;
         faults    = 0;
      endfunction

      function void set_radix(input logic [RADIX_BITS-1:0] r);
         radix_reg = r;
      endfunction

      function int pending();
         return expected_text.size();
      endfunction

      // spell out the accepted word in the current radix
      function void note_value(input logic signed [WORD_BITS-1:0] v);
         logic [WORD_BITS-1:0]  mag;
         logic [WORD_BITS-1:0]  base;
         logic [DIGIT_BITS-1:0] digits[$];
         text_char_type         entry;
         int                    i;
         base = WORD_BITS'(radix_reg);
         if (radix_reg < RADIX_MIN) begin
            base = WORD_BITS'(RADIX_MIN);
         end else if (radix_reg > RADIX_MAX) begin
            base = WORD_BITS'(RADIX_MAX);
         end
         mag = v;
         if (v[WORD_BITS-1]) begin
            mag = ~mag + WORD_BITS'(1);
         end
         // least significant digit first; zero still yields one digit
         do begin
            digits.push_back(DIGIT_BITS'(mag % base));
            mag = mag / base;
         end while (mag != 0);
         if (v[WORD_BITS-1]) begin
            entry.ascii_char = CHAR_MINUS;
            entry.last       = 1'b0;
            expected_text.push_back(entry);
         end
         for (i = digits.size() - 1; i >= 0; i--) begin
            if (digits[i] < 10) begin
               entry.ascii_char = CHAR_ZERO + CHAR_BITS'(digits[i]);
            end else begin
               entry.ascii_char = CHAR_UPPER_A + CHAR_BITS'(digits[i] - 10);
            end
            entry.last = (i == 0);
            expected_text.push_back(entry);
         end
      endfunction

      function void check_char(input logic [CHAR_BITS-1:0] c, input logic l);
         text_char_type want;
         if (expected_text.size() == 0) begin
            faults++;
            if (faults <= 10) begin
               $display("unexpected word: char %h last %b", c, l);
            end
         end else begin
            want = expected_text.pop_front();
            if (c !== want.ascii_char || l !== want.last) begin
               faults++;
               if (faults <= 10) begin
                  $display("mismatch: char exp %h got %h, last exp %b got %b",
                           want.ascii_char, c, want.last, l);
               end
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [RADIX_BITS-1:0] csr_wdata;

   sira_req_if req_bus ();
   sira_rsp_if rsp_bus ();

   radix_text_scoreboard sb = new();

   bit send_idle_on  = 1'b1;
   bit rsp_idle_on   = 1'b1;
   bit hold_request  = 1'b0;
   int phase;
   logic [RADIX_BITS-1:0] pick_radix;

   localparam int LONG_HOLD_CYCLES = 300;

   signed_integer_to_radix_ascii_top uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // offer one word, with an optional idle burst ahead of it
   task automatic push_value(input logic signed [WORD_BITS-1:0] v);
      int gap;
      if (send_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      sb.note_value(v);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_BITS-1:0] r);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_radix(r);
   endtask

   function automatic logic signed [WORD_BITS-1:0] pick_value(
         input logic [RADIX_BITS-1:0] r);
      longint                      p;
      longint                      b;
      int                          k;
      logic signed [WORD_BITS-1:0] v;
      b = longint'(sat_radix(r));
      case ($urandom_range(0, 5))
         0, 1: begin
            v = $urandom;
         end
         2: begin
            v = $urandom_range(0, 100);
         end
         3: begin
            // around a power of the radix, where the digit count steps
            p = 1;
            k = $urandom_range(0, 31);
            repeat (k) begin
               if (p * b <= 64'h7FFF_FFFF) p = p * b;
            end
            v = WORD_BITS'(p + $urandom_range(0, 2) - 1);
         end
         4: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'hFFFF_FFFF;
               default: v = '0;
            endcase
         end
         default: begin
            v = $urandom_range(0, 32'h0001_0000);
         end
      endcase
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   // result side: check accepted words, then pick ready for the next edge
   initial begin
      int stall_left;
      int hold_left;
      stall_left    = 0;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_char(rsp_bus.ascii_char, rsp_bus.last);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = RADIX_RESET;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset radix of ten
      push_value(0);
      push_value(1);
      push_value(-1);
      push_value(32'h7FFF_FFFF);
      push_value(32'h8000_0000);
      push_value(-10);
      // binary: most negative gives the longest string
      write_radix(6'd2);
      push_value(32'h8000_0000);
      push_value(32'h7FFF_FFFF);
      push_value(0);
      // base 36 reaches the top digit Z
      write_radix(6'd36);
      push_value(35);
      push_value(32'h7FFF_FFFF);
      push_value(-36);
      push_value(32'h8000_0000);
      // out-of-range radix saturates
      write_radix(6'd0);
      push_value(5);
      push_value(-5);
      write_radix(6'd63);
      push_value(35);
      push_value(-1295);
      write_radix(6'd37);
      push_value(71);
      write_radix(6'd1);
      push_value(32'hFFFF_FFFF);
      write_radix(6'd16);
      push_value(32'hDEAD_BEEF);
      push_value(32'h1234_5678);

      for (phase = 0; phase < 8; phase++) begin
         pick_radix = ($urandom_range(0, 4) == 0) ? RADIX_BITS'($urandom_range(0, 63))
                                                  : RADIX_BITS'($urandom_range(2, 36));
         write_radix(pick_radix);
         send_idle_on = (phase != 3) && (phase != 7);
         rsp_idle_on  = (phase != 7);
         // long output stall while input keeps coming
         if (phase == 3) hold_request = 1'b1;
         repeat (11) push_value(pick_value(pick_radix));
      end

      wait_drained();
      repeat (150) @(posedge clock);
      if (sb.faults == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/sira_pkg.sv
hdl/sira_req_if.sv
hdl/sira_rsp_if.sv
hdl/sira_div.sv
hdl/signed_integer_to_radix_ascii_top.sv
hdl/sira_checker.sv
bench/signed_integer_to_radix_ascii_top_tb.sv
